/* src/tdhb_pkg.sv */
// shared types and constants of the 3d histogram binning block
package tdhb_pkg;

	localparam int NUM_AXES   = 3;
	localparam int FUNC_W     = 2;
	localparam int COORD_W    = 32;
	localparam int IDX_W      = 15;
	localparam int COUNT_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [COORD_W-1:0] SCALE_RESET = 32'h0001_0000;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

	// operation codes as they arrive in func
	typedef enum logic [FUNC_W-1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN   = 3'd0,
		REG_Y_MIN   = 3'd1,
		REG_Z_MIN   = 3'd2,
		REG_X_SCALE = 3'd3,
		REG_Y_SCALE = 3'd4,
		REG_Z_SCALE = 3'd5
	} cfg_reg_t;

	// classified item handed from front end to back end
	typedef struct packed {
		op_t              op;
		logic             hit;   // touches the store (add in grid, read in range)
		logic [IDX_W-1:0] idx;   // bin_index to report
	} cmd_t;

endpackage

/* src/tdhb_if.sv */
// handshake channels for points in and results out
interface tdhb_req_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           func;
	logic signed [31:0]   x_coord;
	logic signed [31:0]   y_coord;
	logic signed [31:0]   z_coord;
	logic [14:0]          read_index;

	modport source (output valid, func, x_coord, y_coord, z_coord, read_index, input ready);
	modport sink (input valid, func, x_coord, y_coord, z_coord, read_index, output ready);
endinterface

interface tdhb_rsp_if;
	logic        valid;
	logic        ready;
	logic        counted;
	logic [14:0] bin_index;
	logic [31:0] bin_count;

	modport source (output valid, counted, bin_index, bin_count, input ready);
	modport sink (input valid, counted, bin_index, bin_count, output ready);
endinterface

/* src/tdhb_queue.sv */
// small register fifo between the front and back ends
module tdhb_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/tdhb_front.sv */
// front end: config registers, per-axis binning pipeline, item classification
module tdhb_front #(
	parameter int AXIS_BINS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tdhb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tdhb_pkg::CFG_DATA_W-1:0] cfg_data,
	tdhb_req_if.sink                        req,
	input  logic                            init_busy,
	output logic                            push_valid,
	input  logic                            push_ready,
	output tdhb_pkg::cmd_t                  push_cmd,
	output logic [$clog2(AXIS_BINS*AXIS_BINS*AXIS_BINS)-1:0] push_addr
);
	import tdhb_pkg::*;

	localparam int STORE = AXIS_BINS * AXIS_BINS * AXIS_BINS;
	localparam int AW    = $clog2(STORE);
	localparam int BW    = $clog2(AXIS_BINS);

	logic signed [COORD_W-1:0] min_q   [NUM_AXES];
	logic [COORD_W-1:0]        scale_q [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				min_q[a]   <= '0;
				scale_q[a] <= SCALE_RESET;
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_X_MIN:   min_q[0]   <= cfg_data;
				REG_Y_MIN:   min_q[1]   <= cfg_data;
				REG_Z_MIN:   min_q[2]   <= cfg_data;
				REG_X_SCALE: scale_q[0] <= cfg_data;
				REG_Y_SCALE: scale_q[1] <= cfg_data;
				REG_Z_SCALE: scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic                      v_s1;
	logic                      v_s2;
	logic                      adv1;
	logic                      adv2;
	logic                      acc;
	op_t                       op_s1;
	op_t                       op_s2;
	logic [IDX_W-1:0]          ridx_s1;
	logic [IDX_W-1:0]          ridx_s2;
	logic [COORD_W-1:0]        diff_s1 [NUM_AXES];
	logic                      neg_s1  [NUM_AXES];
	logic [BW-1:0]             bin_s2  [NUM_AXES];
	logic                      ok_s2   [NUM_AXES];
	logic signed [COORD_W-1:0] coord_c [NUM_AXES];
	logic [COORD_W:0]          diff_c  [NUM_AXES];
	logic [2*COORD_W-1:0]      prod_c  [NUM_AXES];
	logic [COORD_W-1:0]        hi_c    [NUM_AXES];
	logic [BW-1:0]             bin_c   [NUM_AXES];
	logic                      ok_c    [NUM_AXES];

	assign adv2      = !v_s2 || push_ready;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1 && !init_busy;
	assign acc       = req.valid && req.ready;

	assign coord_c[0] = req.x_coord;
	assign coord_c[1] = req.y_coord;
	assign coord_c[2] = req.z_coord;

	// exact 33-bit offset from the axis minimum
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			diff_c[a] = {coord_c[a][COORD_W-1], coord_c[a]} - {min_q[a][COORD_W-1], min_q[a]};
		end
	end

	// offset times scale, keep the integer part; negative offset only lands with zero scale
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			prod_c[a] = diff_s1[a] * scale_q[a];
			hi_c[a]   = prod_c[a][2*COORD_W-1:COORD_W];
			ok_c[a]   = neg_s1[a] ? (scale_q[a] == '0) : (hi_c[a] < COORD_W'(AXIS_BINS));
			bin_c[a]  = neg_s1[a] ? '0 : hi_c[a][BW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= acc;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && acc) begin
			op_s1   <= op_t'(req.func);
			ridx_s1 <= req.read_index;
			for (int a = 0; a < NUM_AXES; a++) begin
				diff_s1[a] <= diff_c[a][COORD_W-1:0];
				neg_s1[a]  <= diff_c[a][COORD_W];
			end
		end
		if (adv2 && v_s1) begin
			op_s2   <= op_s1;
			ridx_s2 <= ridx_s1;
			for (int a = 0; a < NUM_AXES; a++) begin
				bin_s2[a] <= bin_c[a];
				ok_s2[a]  <= ok_c[a];
			end
		end
	end

	logic [31:0] flat_c;
	logic [31:0] ridx_w;

	assign flat_c = 32'(bin_s2[2]) * 32'(AXIS_BINS * AXIS_BINS)
	              + 32'(bin_s2[1]) * 32'(AXIS_BINS) + 32'(bin_s2[0]);
	assign ridx_w = 32'(ridx_s2);

	assign push_valid = v_s2;

	always_comb begin
		push_cmd.op  = op_s2;
		push_cmd.hit = 1'b0;
		push_cmd.idx = '0;
		push_addr    = '0;
		case (op_s2)
			OP_ADD: begin
				if (ok_s2[0] && ok_s2[1] && ok_s2[2]) begin
					push_cmd.hit = 1'b1;
					push_cmd.idx = flat_c[IDX_W-1:0];
					push_addr    = flat_c[AW-1:0];
				end
			end
			OP_READ: begin
				push_cmd.hit = ridx_w < 32'(STORE);
				push_cmd.idx = ridx_s2;
				push_addr    = ridx_w[AW-1:0];
			end
			default: ;
		endcase
	end

endmodule

/* src/tdhb_back.sv */
// back end: bin store, read-modify-write, clear sweep and result register
module tdhb_back #(
	parameter int AXIS_BINS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  tdhb_pkg::cmd_t       pop_cmd,
	input  logic [$clog2(AXIS_BINS*AXIS_BINS*AXIS_BINS)-1:0] pop_addr,
	output logic                 init_busy,
	tdhb_rsp_if.source           rsp
);
	import tdhb_pkg::*;

	localparam int STORE = AXIS_BINS * AXIS_BINS * AXIS_BINS;
	localparam int AW    = $clog2(STORE);

	typedef enum logic [3:0] {
		ST_INIT = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_RD   = 4'b0100,
		ST_CLR  = 4'b1000
	} state_t;

	state_t           st_q;
	logic [AW-1:0]    cursor_q;
	cmd_t             cmd_q;
	logic [AW-1:0]    addr_q;
	logic [COUNT_W-1:0] rd_data_q;
	logic [COUNT_W-1:0] mem [STORE];

	logic               out_valid_q;
	logic               out_counted_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               out_free;
	logic               do_pop;
	logic               cursor_last;
	logic [COUNT_W-1:0] inc_c;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [COUNT_W-1:0] mem_wdata;
	logic               mem_re;
	logic               load_out;
	logic               ld_counted;
	logic [IDX_W-1:0]   ld_idx;
	logic [COUNT_W-1:0] ld_count;

	assign out_free    = !out_valid_q || rsp.ready;
	assign pop_ready   = (st_q == ST_IDLE) && out_free;
	assign do_pop      = pop_valid && pop_ready;
	assign cursor_last = cursor_q == AW'(STORE - 1);
	assign init_busy   = st_q == ST_INIT;
	assign inc_c       = (rd_data_q == COUNT_MAX) ? rd_data_q : rd_data_q + 1'b1;
	assign mem_re      = do_pop && pop_cmd.hit;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cursor_q;
		mem_wdata = '0;
		case (st_q)
			ST_INIT, ST_CLR: mem_we = 1'b1;
			ST_RD: begin
				mem_we    = cmd_q.op == OP_ADD;
				mem_waddr = addr_q;
				mem_wdata = inc_c;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[pop_addr];
		end
	end

	// result to load this cycle, if any
	always_comb begin
		load_out   = 1'b0;
		ld_counted = 1'b0;
		ld_idx     = '0;
		ld_count   = '0;
		case (st_q)
			ST_IDLE: begin
				load_out = do_pop && !pop_cmd.hit && (pop_cmd.op != OP_CLEAR);
				ld_idx   = pop_cmd.idx;
			end
			ST_RD: begin
				load_out   = 1'b1;
				ld_counted = cmd_q.op == OP_ADD;
				ld_idx     = cmd_q.idx;
				ld_count   = (cmd_q.op == OP_ADD) ? inc_c : rd_data_q;
			end
			ST_CLR: load_out = cursor_last;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INIT;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_INIT, ST_CLR: begin
					if (cursor_last) begin
						cursor_q <= '0;
						st_q     <= ST_IDLE;
					end else begin
						cursor_q <= cursor_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (do_pop && pop_cmd.op == OP_CLEAR) begin
						st_q <= ST_CLR;
					end else if (mem_re) begin
						st_q <= ST_RD;
					end
				end
				ST_RD: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			cmd_q  <= pop_cmd;
			addr_q <= pop_addr;
		end
		if (load_out) begin
			out_counted_q <= ld_counted;
			out_idx_q     <= ld_idx;
			out_count_q   <= ld_count;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.counted   = out_counted_q;
	assign rsp.bin_index = out_idx_q;
	assign rsp.bin_count = out_count_q;

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_INIT |-> !out_valid_q)
		else $error("result shown during reset clearing pass");

	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_counted_q |-> out_count_q != '0)
		else $error("counted point reports a zero count");

	a_rd_single: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RD |=> st_q == ST_IDLE && out_valid_q)
		else $error("store access did not finish with a result");

	a_rd_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RD |-> $past(mem_re))
		else $error("store access without a popped item");

endmodule

/* src/three_d_histogram_binning.sv */
// top level of the uniform-bin 3d histogram
//
// Points arrive on req as signed Q16.16 coordinates; each axis bin is
// floor((coord - min) * scale / 2^32) with an exact 33-bit offset, and a
// point counts only when all three bins lie in [0, AXIS_BINS). The front
// end holds the six config registers and bins a point in two pipeline
// stages (offset, then the 32x32 multiply), classifies the item and
// pushes it into a QUEUE_DEPTH-entry queue, so until that fills it keeps
// taking items while the back end is busy or a result waits on rsp. The
// back end owns the AXIS_BINS^3 x 32-bit bin store (one write port, one
// registered read port): an in-grid add or an in-range read first reads
// the bin, then increments and writes it or reports it; a dropped point,
// an out-of-range read or an unused func code skips the store, and a
// clear zeroes one bin a cycle. Every item yields exactly one result
// item. After reset the back end runs the same sweep over all
// AXIS_BINS^3 bins (32768 at the default) with req.ready low; config
// writes are taken at any time but belong in idle periods.
module three_d_histogram_binning #(
	parameter int AXIS_BINS   = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tdhb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tdhb_pkg::CFG_DATA_W-1:0] cfg_data,
	tdhb_req_if.sink                        req,
	tdhb_rsp_if.source                      rsp
);
	import tdhb_pkg::*;

	localparam int STORE = AXIS_BINS * AXIS_BINS * AXIS_BINS;
	localparam int AW    = $clog2(STORE);
	localparam int QW    = $bits(cmd_t) + AW;

	// front end to queue
	logic          push_valid;
	logic          push_ready;
	cmd_t          push_cmd;
	logic [AW-1:0] push_addr;

	// queue to back end
	logic          pop_valid;
	logic          pop_ready;
	logic [QW-1:0] pop_data;
	cmd_t          pop_cmd;
	logic [AW-1:0] pop_addr;

	// high while the store is swept after reset
	logic          init_busy;

	tdhb_front #(
		.AXIS_BINS (AXIS_BINS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.req        (req),
		.init_busy  (init_busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.push_addr  (push_addr)
	);

	// classified items wait here, command above the store address
	tdhb_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_cmd, push_addr}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_cmd  = cmd_t'(pop_data[QW-1:AW]);
	assign pop_addr = pop_data[AW-1:0];

	tdhb_back #(
		.AXIS_BINS (AXIS_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.pop_addr  (pop_addr),
		.init_busy (init_busy),
		.rsp       (rsp)
	);

endmodule
